/* sv/pfvi_pkg.sv */
// Shared types, constants and the microcode ROM for the pitot flow volume integrator.
// No dependencies; used by pfvi_datapath and pitot_flow_volume_integrator_top.
package pfvi_pkg;

    // Fixed-point format and field widths
    localparam int FRAC_BITS  = 16;
    localparam int SAMPLE_W   = 12;
    localparam int COEF_W     = 32;
    localparam int THR_W      = 47;
    localparam int SUM_W      = 48;
    localparam int VOL_W      = 47;
    localparam int TOT_W      = 63;
    localparam int PROD_W     = COEF_W + SAMPLE_W;
    localparam int ACC_W      = 48;
    localparam int RAD_W      = 64;
    localparam int ROOT_W     = RAD_W / 2;
    localparam int REM_W      = ROOT_W + 2;
    localparam int ROOT_STEPS = RAD_W / 2;
    localparam int CNT_W      = $clog2(ROOT_STEPS);
    localparam int MULF_W     = 2 * COEF_W;

    // Stream and config port widths
    localparam int S_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((VOL_W + TOT_W + 7) / 8) * 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 47;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_OFFSET  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AIR_DENSITY      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FLOW_GAIN        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME_THRESHOLD = 3'd4;

    localparam logic [COEF_W-1:0] GAIN_ONE = COEF_W'(1) << FRAC_BITS;

    typedef struct packed {
        logic        [COEF_W-1:0] pressure_gain;
        logic signed [COEF_W-1:0] pressure_offset;
        logic        [COEF_W-1:0] air_density;
        logic        [COEF_W-1:0] flow_gain;
        logic        [THR_W-1:0]  volume_threshold;
    } cfg_t;

    // Datapath operations
    typedef logic [3:0] op_t;
    localparam op_t OP_NOP       = 4'd0;
    localparam op_t OP_MUL_P     = 4'd1;
    localparam op_t OP_SUB_OFF   = 4'd2;
    localparam op_t OP_SUB_DEN   = 4'd3;
    localparam op_t OP_ROOT_INIT = 4'd4;
    localparam op_t OP_ROOT_STEP = 4'd5;
    localparam op_t OP_MUL_F     = 4'd6;
    localparam op_t OP_ACC       = 4'd7;
    localparam op_t OP_THRESH    = 4'd8;
    localparam op_t OP_EMIT      = 4'd9;

    // Jump conditions
    typedef logic [2:0] cond_t;
    localparam cond_t COND_NONE       = 3'd0;
    localparam cond_t COND_ALWAYS     = 3'd1;
    localparam cond_t COND_NO_INPUT   = 3'd2;
    localparam cond_t COND_RAD_NONPOS = 3'd3;
    localparam cond_t COND_ROOT_MORE  = 3'd4;
    localparam cond_t COND_NOT_LAST   = 3'd5;
    localparam cond_t COND_OUT_BUSY   = 3'd6;

    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] pc_t;
    localparam pc_t PC_IDLE = 4'd0;
    localparam pc_t PC_ROOT = 4'd5;
    localparam pc_t PC_MULF = 4'd6;
    localparam pc_t PC_EMIT = 4'd9;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } uword_t;

    typedef struct packed {
        logic load;
        op_t  op;
    } ctl_t;

    typedef struct packed {
        logic rad_nonpos;
        logic root_more;
        logic last;
    } stat_t;

    typedef struct packed {
        logic [TOT_W-1:0] total;
        logic [VOL_W-1:0] vol;
    } result_t;

    // Microprogram: one control word per step
    function automatic uword_t ucode(input pc_t pc);
        uword_t w;
        unique case (pc)
            4'd0:    w = '{op: OP_NOP,       cond: COND_NO_INPUT,   target: PC_IDLE};
            4'd1:    w = '{op: OP_MUL_P,     cond: COND_NONE,       target: PC_IDLE};
            4'd2:    w = '{op: OP_SUB_OFF,   cond: COND_NONE,       target: PC_IDLE};
            4'd3:    w = '{op: OP_SUB_DEN,   cond: COND_NONE,       target: PC_IDLE};
            4'd4:    w = '{op: OP_ROOT_INIT, cond: COND_RAD_NONPOS, target: PC_MULF};
            4'd5:    w = '{op: OP_ROOT_STEP, cond: COND_ROOT_MORE,  target: PC_ROOT};
            4'd6:    w = '{op: OP_MUL_F,     cond: COND_NONE,       target: PC_IDLE};
            4'd7:    w = '{op: OP_ACC,       cond: COND_NOT_LAST,   target: PC_IDLE};
            4'd8:    w = '{op: OP_THRESH,    cond: COND_NONE,       target: PC_IDLE};
            4'd9:    w = '{op: OP_EMIT,      cond: COND_OUT_BUSY,   target: PC_EMIT};
            default: w = '{op: OP_NOP,       cond: COND_ALWAYS,     target: PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

/* sv/pfvi_datapath.sv */
// Arithmetic datapath of the flow integrator: multiplier, adders, root step, accumulators.
// Driven one operation per cycle by the sequencer in the top level; uses pfvi_pkg.
module pfvi_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  pfvi_pkg::cfg_t                cfg,
    input  pfvi_pkg::ctl_t                ctl,
    input  logic [pfvi_pkg::SAMPLE_W-1:0] sample,
    input  logic                          end_of_second,
    output pfvi_pkg::stat_t               stat,
    output pfvi_pkg::result_t             result
);

    logic [pfvi_pkg::SAMPLE_W-1:0]    sample_reg;
    logic                             last_reg;
    logic [pfvi_pkg::PROD_W-1:0]      prod_reg;
    logic signed [pfvi_pkg::ACC_W-1:0] acc_reg;
    logic [pfvi_pkg::RAD_W-1:0]       v_reg;
    logic [pfvi_pkg::REM_W-1:0]       rem_reg;
    logic [pfvi_pkg::ROOT_W-1:0]      root_reg;
    logic [pfvi_pkg::CNT_W-1:0]       cnt_reg;
    logic [pfvi_pkg::SUM_W-1:0]       flow_reg;
    logic [pfvi_pkg::VOL_W-1:0]       vol_reg;
    logic [pfvi_pkg::SUM_W-1:0]       ws_reg;
    logic                             prev_reg;
    logic [pfvi_pkg::TOT_W-1:0]       total_reg;

    logic [pfvi_pkg::PROD_W-1:0]       prod_next;
    logic signed [pfvi_pkg::ACC_W-1:0] press_next;
    logic signed [pfvi_pkg::ACC_W-1:0] rad_next;
    logic [pfvi_pkg::RAD_W-1:0]        v_init;
    logic [pfvi_pkg::REM_W+1:0]        rem_sh;
    logic [pfvi_pkg::REM_W+1:0]        trial;
    logic                              ge;
    logic [pfvi_pkg::REM_W-1:0]        rem_next;
    logic [pfvi_pkg::MULF_W-1:0]       mulf;
    logic [pfvi_pkg::SUM_W:0]          ws_sum;
    logic [pfvi_pkg::SUM_W-1:0]        ws_acc;
    logic [pfvi_pkg::VOL_W-1:0]        vol_next;
    logic [pfvi_pkg::TOT_W:0]          tot_sum;
    logic [pfvi_pkg::TOT_W-1:0]        total_next;
    logic                              rad_nonpos;

    assign prod_next  = pfvi_pkg::PROD_W'(cfg.pressure_gain)
                      * pfvi_pkg::PROD_W'(sample_reg);
    assign press_next = $signed({{(pfvi_pkg::ACC_W-pfvi_pkg::PROD_W){1'b0}}, prod_reg})
                      - pfvi_pkg::ACC_W'(cfg.pressure_offset);
    assign rad_next   = (acc_reg <<< 1)
                      - $signed({{(pfvi_pkg::ACC_W-pfvi_pkg::COEF_W){1'b0}}, cfg.air_density});

    assign rad_nonpos = acc_reg[pfvi_pkg::ACC_W-1] || (acc_reg == '0);

    // A positive radicand fits in ACC_W-1 bits, below the 2^(64-FRAC)-1 clamp,
    // so the root input is the radicand moved up by FRAC_BITS.
    assign v_init = rad_nonpos ? '0
                  : pfvi_pkg::RAD_W'(acc_reg[pfvi_pkg::ACC_W-2:0]) << pfvi_pkg::FRAC_BITS;

    // Restoring square root, two radicand bits per step
    assign rem_sh   = {rem_reg, v_reg[pfvi_pkg::RAD_W-1 -: 2]};
    assign trial    = (pfvi_pkg::REM_W+2)'({root_reg, 2'b01});
    assign ge       = (rem_sh >= trial);
    assign rem_next = ge ? pfvi_pkg::REM_W'(rem_sh - trial) : pfvi_pkg::REM_W'(rem_sh);

    assign mulf = pfvi_pkg::MULF_W'(cfg.flow_gain) * pfvi_pkg::MULF_W'(root_reg);

    assign ws_sum = {1'b0, ws_reg} + {1'b0, flow_reg};
    assign ws_acc = ws_sum[pfvi_pkg::SUM_W] ? {pfvi_pkg::SUM_W{1'b1}}
                                           : ws_sum[pfvi_pkg::SUM_W-1:0];

    always_comb
    begin
        if (ws_reg <= {1'b0, cfg.volume_threshold})
        begin
            vol_next = '0;
        end
        else if (ws_reg[pfvi_pkg::SUM_W-1])
        begin
            vol_next = {pfvi_pkg::VOL_W{1'b1}};
        end
        else
        begin
            vol_next = ws_reg[pfvi_pkg::VOL_W-1:0];
        end
    end

    assign tot_sum = {1'b0, total_reg} + (pfvi_pkg::TOT_W+1)'(vol_reg);

    always_comb
    begin
        if (vol_reg == '0)
        begin
            // zero window: clear the total only after another zero window
            total_next = prev_reg ? total_reg : '0;
        end
        else if (tot_sum[pfvi_pkg::TOT_W])
        begin
            total_next = {pfvi_pkg::TOT_W{1'b1}};
        end
        else
        begin
            total_next = tot_sum[pfvi_pkg::TOT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            sample_reg <= sample;
            last_reg   <= end_of_second;
        end
        case (ctl.op)
            pfvi_pkg::OP_MUL_P:     prod_reg <= prod_next;
            pfvi_pkg::OP_SUB_OFF:   acc_reg  <= press_next;
            pfvi_pkg::OP_SUB_DEN:   acc_reg  <= rad_next;
            pfvi_pkg::OP_ROOT_INIT:
            begin
                v_reg    <= v_init;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
            end
            pfvi_pkg::OP_ROOT_STEP:
            begin
                v_reg    <= v_reg << 2;
                rem_reg  <= rem_next;
                root_reg <= {root_reg[pfvi_pkg::ROOT_W-2:0], ge};
                cnt_reg  <= cnt_reg + 1'b1;
            end
            pfvi_pkg::OP_MUL_F:     flow_reg <= mulf[pfvi_pkg::FRAC_BITS +: pfvi_pkg::SUM_W];
            pfvi_pkg::OP_THRESH:    vol_reg  <= vol_next;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg    <= '0;
            prev_reg  <= 1'b0;
            total_reg <= '0;
        end
        else
        begin
            case (ctl.op)
                pfvi_pkg::OP_ACC:    ws_reg <= ws_acc;
                pfvi_pkg::OP_THRESH: ws_reg <= '0;
                pfvi_pkg::OP_EMIT:
                begin
                    total_reg <= total_next;
                    prev_reg  <= (vol_reg != '0);
                end
                default:
                begin
                end
            endcase
        end
    end

    assign stat.rad_nonpos = rad_nonpos;
    assign stat.root_more  = (cnt_reg != pfvi_pkg::CNT_W'(pfvi_pkg::ROOT_STEPS - 1));
    assign stat.last       = last_reg;

    assign result.total = total_next;
    assign result.vol   = vol_reg;

endmodule

/* sv/pitot_flow_volume_integrator_top.sv */
// Top level of the pitot flow volume integrator: stream ports, config registers,
// microcode sequencer and output register. Uses pfvi_pkg and pfvi_datapath.

// Each sample beat runs through a short microprogram: pressure product, offset and
// density subtraction, a 32-step restoring square root, the flow multiply and the
// window accumulate. s_tready stays low until the microprogram is back at its idle
// step, so a new sample is taken only once the last one is through; a sample with
// zero or negative radicand skips the root. The last sample of a window adds the
// thresholding, the total update with the output load, and the return step, and the
// output load waits while the output register is still held by the sink. The result
// beat sits in its own register, so the next sample is taken while it waits.
module pitot_flow_volume_integrator_top
(
    input  logic                            clk,
    input  logic                            rst_n,
    // sample beats
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pfvi_pkg::S_TDATA_W-1:0]  s_tdata,   // [11:0] sample
    input  logic                            s_tlast,   // end_of_second
    // window result beats
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pfvi_pkg::M_TDATA_W-1:0]  m_tdata,   // [46:0] second_volume, [109:47] total_volume
    // register writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pfvi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pfvi_pkg::CFG_DATA_W-1:0] cfg_data
);

    pfvi_pkg::cfg_t    cfg_reg;
    pfvi_pkg::pc_t     pc_reg;
    pfvi_pkg::pc_t     pc_next;
    pfvi_pkg::uword_t  uw;
    pfvi_pkg::ctl_t    ctl;
    pfvi_pkg::stat_t   stat;
    pfvi_pkg::result_t result;
    logic                           m_tvalid_reg;
    logic [pfvi_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic                           out_free;
    logic                           jump;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pressure_gain    <= pfvi_pkg::GAIN_ONE;
            cfg_reg.pressure_offset  <= '0;
            cfg_reg.air_density      <= '0;
            cfg_reg.flow_gain        <= pfvi_pkg::GAIN_ONE;
            cfg_reg.volume_threshold <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                pfvi_pkg::REG_PRESSURE_GAIN:
                    cfg_reg.pressure_gain <= cfg_data[pfvi_pkg::COEF_W-1:0];
                pfvi_pkg::REG_PRESSURE_OFFSET:
                    cfg_reg.pressure_offset <= $signed(cfg_data[pfvi_pkg::COEF_W-1:0]);
                pfvi_pkg::REG_AIR_DENSITY:
                    cfg_reg.air_density <= cfg_data[pfvi_pkg::COEF_W-1:0];
                pfvi_pkg::REG_FLOW_GAIN:
                    cfg_reg.flow_gain <= cfg_data[pfvi_pkg::COEF_W-1:0];
                pfvi_pkg::REG_VOLUME_THRESHOLD:
                    cfg_reg.volume_threshold <= cfg_data[pfvi_pkg::THR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer
    assign uw       = pfvi_pkg::ucode(pc_reg);
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (pc_reg == pfvi_pkg::PC_IDLE);

    always_comb
    begin
        unique case (uw.cond)
            pfvi_pkg::COND_NONE:       jump = 1'b0;
            pfvi_pkg::COND_ALWAYS:     jump = 1'b1;
            pfvi_pkg::COND_NO_INPUT:   jump = !s_tvalid;
            pfvi_pkg::COND_RAD_NONPOS: jump = stat.rad_nonpos;
            pfvi_pkg::COND_ROOT_MORE:  jump = stat.root_more;
            pfvi_pkg::COND_NOT_LAST:   jump = !stat.last;
            pfvi_pkg::COND_OUT_BUSY:   jump = !out_free;
            default:                   jump = 1'b1;
        endcase
        pc_next = jump ? uw.target : pc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= pfvi_pkg::PC_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    // The emit step only fires once the output register is free
    assign ctl.load = s_tvalid && s_tready;
    assign ctl.op   = (uw.op == pfvi_pkg::OP_EMIT && !out_free) ? pfvi_pkg::OP_NOP : uw.op;

    pfvi_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .ctl           (ctl),
        .sample        (s_tdata[pfvi_pkg::SAMPLE_W-1:0]),
        .end_of_second (s_tlast),
        .stat          (stat),
        .result        (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (ctl.op == pfvi_pkg::OP_EMIT)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.op == pfvi_pkg::OP_EMIT)
        begin
            m_tdata_reg <= pfvi_pkg::M_TDATA_W'({result.total, result.vol});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* verif/pfvi_flow_checker.sv */
// Checker for the pitot flow volume integrator: watches the sample, result and
// register channels, predicts each window result and compares it field by field.
// Depends on pfvi_pkg for widths, register indexes and the result layout.
module pfvi_flow_checker
    import pfvi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tlast,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    windows_pending
);

    localparam logic [SUM_W-1:0] SUM_FULL = '1;
    localparam logic [VOL_W-1:0] VOL_FULL = '1;
    localparam logic [TOT_W-1:0] TOT_FULL = '1;

    logic        [COEF_W-1:0] gain_q;
    logic signed [COEF_W-1:0] offset_q;
    logic        [COEF_W-1:0] density_q;
    logic        [COEF_W-1:0] flow_gain_q;
    logic        [THR_W-1:0]  threshold_q;

    logic [SUM_W-1:0] window_acc;
    logic             last_window_nonzero;
    logic [TOT_W-1:0] total_acc;
    result_t          results_due[$];
    int               fail_count;

    function automatic logic [31:0] floor_root64(input logic [63:0] v);
        logic [31:0] r;
        logic [31:0] c;
        r = '0;
        for (int i = 31; i >= 0; i--)
        begin
            c = r | (32'd1 << i);
            if (64'(c) * 64'(c) <= v)
                r = c;
        end
        return r;
    endfunction

    // Flow of one sample: gain*sample - offset, doubled, minus density, rooted in Q16.16
    function automatic logic [SUM_W-1:0] flow_for_sample(input logic [SAMPLE_W-1:0] smp);
        logic        [PROD_W-1:0] raw;
        logic signed [65:0]       offset_ext;
        logic signed [65:0]       press;
        logic signed [65:0]       rad;
        logic        [63:0]       scaled;
        logic        [31:0]       root;
        logic        [63:0]       prod;
        raw        = PROD_W'(gain_q) * PROD_W'(smp);
        offset_ext = offset_q;
        press      = $signed({22'd0, raw}) - offset_ext;
        rad        = (press <<< 1) - $signed({34'd0, density_q});
        if (rad <= 0)
            return '0;
        if (rad[65:64-FRAC_BITS] != '0)
            rad = {{(FRAC_BITS+2){1'b0}}, {(64-FRAC_BITS){1'b1}}};
        scaled = 64'(rad[63-FRAC_BITS:0]) << FRAC_BITS;
        root   = floor_root64(scaled);
        prod   = 64'(flow_gain_q) * 64'(root);
        return SUM_W'(prod >> FRAC_BITS);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        fail_count++;
        if (fail_count <= 40)
            $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $time);
    endtask

    task automatic close_window();
        logic [SUM_W-1:0] vol_wide;
        logic [VOL_W-1:0] vol;
        logic [TOT_W:0]   tot_next;
        result_t          r;
        vol_wide   = window_acc;
        window_acc = '0;
        if (vol_wide <= {1'b0, threshold_q})
            vol_wide = '0;
        vol = (vol_wide > {1'b0, VOL_FULL}) ? VOL_FULL : vol_wide[VOL_W-1:0];
        if (vol == '0)
        begin
            // two empty windows in a row drop the total; one only clears the flag
            if (!last_window_nonzero)
                total_acc = '0;
            else
                last_window_nonzero = 1'b0;
        end
        else
        begin
            tot_next  = {1'b0, total_acc} + (TOT_W+1)'(vol);
            total_acc = tot_next[TOT_W] ? TOT_FULL : tot_next[TOT_W-1:0];
            last_window_nonzero = 1'b1;
        end
        r.vol   = vol;
        r.total = total_acc;
        results_due.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t        got;
        result_t        want;
        logic [SUM_W:0] sum_next;
        if (!rst_n)
        begin
            gain_q              = GAIN_ONE;
            offset_q            = '0;
            density_q           = '0;
            flow_gain_q         = GAIN_ONE;
            threshold_q         = '0;
            window_acc          = '0;
            last_window_nonzero = 1'b0;
            total_acc           = '0;
            results_due.delete();
            fail_count          = 0;
            mismatches         <= 0;
            windows_pending    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PRESSURE_GAIN:    gain_q      = cfg_data[COEF_W-1:0];
                    REG_PRESSURE_OFFSET:  offset_q    = cfg_data[COEF_W-1:0];
                    REG_AIR_DENSITY:      density_q   = cfg_data[COEF_W-1:0];
                    REG_FLOW_GAIN:        flow_gain_q = cfg_data[COEF_W-1:0];
                    REG_VOLUME_THRESHOLD: threshold_q = cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end
            // result beat first: it can never belong to a window closed at this edge
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[VOL_W+TOT_W-1:0];
                if (results_due.size() == 0)
                    report_mismatch("result beat with no window pending", 64'(got.vol),
                                    64'(got.total));
                else
                begin
                    want = results_due.pop_front();
                    if (got.vol !== want.vol)
                        report_mismatch("second_volume", 64'(got.vol), 64'(want.vol));
                    if (got.total !== want.total)
                        report_mismatch("total_volume", 64'(got.total), 64'(want.total));
                end
            end
            if (s_tvalid && s_tready)
            begin
                sum_next   = {1'b0, window_acc} +
                             (SUM_W+1)'(flow_for_sample(s_tdata[SAMPLE_W-1:0]));
                window_acc = sum_next[SUM_W] ? SUM_FULL : sum_next[SUM_W-1:0];
                if (s_tlast)
                    close_window();
            end
            mismatches      <= fail_count;
            windows_pending <= results_due.size();
        end
    end

endmodule

/* verif/tb_pitot_flow_volume_integrator_top.sv */
// Testbench top for the pitot flow volume integrator: clock, reset, sample and
// register stimulus, result sink and verdict. Depends on pfvi_pkg, pfvi_flow_checker
// and pitot_flow_volume_integrator_top.
module tb_pitot_flow_volume_integrator_top
    import pfvi_pkg::*;
;

    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 64;
    localparam logic [CFG_IDX_W-1:0] REG_NONE = REG_VOLUME_THRESHOLD + 3'd1;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;   // [11:0] sample
    logic                  s_tlast = 1'b0; // end_of_second
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;        // [46:0] second_volume, [109:47] total_volume
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int mismatches;
    int windows_pending;
    bit idle_on = 1'b1;
    int sink_stall_left = 0;
    int quiet_cycles = 0;
    int n_samples = 0;
    int n_windows = 0;
    int n_settings = 0;

    pitot_flow_volume_integrator_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pfvi_flow_checker i_flow_check
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .windows_pending (windows_pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result sink with random stall bursts
    always @(posedge clk)
    begin
        if (sink_stall_left != 0)
        begin
            sink_stall_left <= sink_stall_left - 1;
            m_tready        <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            sink_stall_left <= $urandom_range(1, 15) - 1;
            m_tready        <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // valid stays high across back-to-back beats; it drops only for a gap
    task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic lst);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(smp);
        s_tlast  <= lst;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        n_samples++;
        if (lst)
            n_windows++;
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (windows_pending != 0)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        hold_until_drained();
        // a sample with no result may still be in the root loop
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // upper data bits of the 32-bit registers carry noise that must be dropped
    task automatic load_settings(input logic [COEF_W-1:0] gain, input logic [COEF_W-1:0] offset,
                                 input logic [COEF_W-1:0] density, input logic [COEF_W-1:0] fgain,
                                 input logic [THR_W-1:0] thr, input bit stray_write);
        write_reg(REG_PRESSURE_GAIN, {15'($urandom), gain});
        write_reg(REG_PRESSURE_OFFSET, {15'($urandom), offset});
        write_reg(REG_AIR_DENSITY, {15'($urandom), density});
        write_reg(REG_FLOW_GAIN, {15'($urandom), fgain});
        write_reg(REG_VOLUME_THRESHOLD, thr);
        if (stray_write)
            write_reg(REG_NONE + CFG_IDX_W'($urandom_range(0, 2)), CFG_DATA_W'({$urandom, $urandom}));
        n_settings++;
    endtask

    initial
    begin
        logic [COEF_W-1:0]   g;
        logic [COEF_W-1:0]   o;
        logic [COEF_W-1:0]   d;
        logic [COEF_W-1:0]   f;
        logic [THR_W-1:0]    t;
        logic [SAMPLE_W-1:0] smp;
        int                  left;
        int                  len;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: empty window sequences and all-ones / alternating samples
        n_settings = 1;
        send_sample('0, 1'b1);
        send_sample('1, 1'b0);
        send_sample('1, 1'b1);
        send_sample('0, 1'b1);
        send_sample('0, 1'b1);
        send_sample(12'hAAA, 1'b0);
        send_sample(12'h555, 1'b1);
        send_sample(12'h001, 1'b1);

        // large positive offset drives the radicand negative
        wait_idle();
        load_settings(GAIN_ONE, 32'h7FFF_FFFF, '0, GAIN_ONE, '0, 1'b1);
        send_sample('1, 1'b1);
        send_sample('0, 1'b1);

        // full-scale gains: window sum saturates, volume clips to its width
        wait_idle();
        load_settings('1, 32'h8000_0000, '0, '1, '0, 1'b0);
        repeat (4) send_sample('1, 1'b0);
        send_sample('1, 1'b1);
        send_sample('1, 1'b1);

        // maximum threshold: one sample falls under it, a saturated sum does not
        wait_idle();
        load_settings('1, 32'h8000_0000, '0, '1, '1, 1'b0);
        send_sample('1, 1'b1);
        repeat (3) send_sample('1, 1'b0);
        send_sample('1, 1'b1);

        for (int ph = 0; ph < 5; ph++)
        begin
            wait_idle();
            idle_on = (ph != 4);
            case ($urandom_range(0, 4))
                0:       g = '0;
                1:       g = '1;
                2:       g = $urandom;
                default: g = $urandom_range(1 << 12, 1 << 20);
            endcase
            case ($urandom_range(0, 3))
                0:       o = '0;
                1:       o = $urandom;
                default: o = 32'($urandom_range(0, 1 << 24)) - 32'(1 << 23);
            endcase
            case ($urandom_range(0, 3))
                0:       d = '0;
                1:       d = $urandom;
                default: d = $urandom_range(0, 1 << 24);
            endcase
            case ($urandom_range(0, 5))
                0:       f = '0;
                1:       f = '1;
                2:       f = $urandom;
                default: f = $urandom_range(1 << 12, 1 << 20);
            endcase
            case ($urandom_range(0, 4))
                0:       t = '0;
                1:       t = '1;
                2:       t = THR_W'({$urandom, $urandom});
                default: t = THR_W'($urandom) << $urandom_range(0, 15);
            endcase
            if (ph == 0)
            begin
                g = '1;
                f = '1;
            end
            load_settings(g, o, d, f, t, $urandom_range(0, 1));

            left = 80;
            while (left > 0)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
                for (int k = 0; k < len && left > 0; k++)
                begin
                    if ($urandom_range(0, 7) == 0)
                        smp = $urandom_range(0, 1) ? '1 : '0;
                    else
                        smp = SAMPLE_W'($urandom);
                    send_sample(smp, k == len - 1);
                    left--;
                    if (ph == 1 && left == 40)
                        hold_until_drained();
                end
            end
        end

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d samples in %0d closed windows under %0d register settings,",
                 n_samples, n_windows, n_settings);
        $display("including saturating sums, negative radicands and empty-window sequences.");
        if (mismatches == 0 && windows_pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
